// File: rtl/tpme_pkg.sv
package tpme_pkg;

   localparam int NODE_W    = 10;
   localparam int MAX_NODES = 1 << NODE_W;
   localparam int LEVELS    = 10;
   localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int ANC_W     = NODE_W + 1;
   localparam int WEIGHT_W  = 32;
   localparam int DEPTH_W   = NODE_W;
   localparam int ADDR_W    = LVL_W + NODE_W;
   localparam int MEM_DEPTH = LEVELS * MAX_NODES;
   localparam int DIST_W    = ((DEPTH_W > LEVELS) ? DEPTH_W : LEVELS) + 1;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 32;

   // request tdata field offsets
   localparam int CHILD_LSB  = 0;
   localparam int PARENT_LSB = CHILD_LSB + NODE_W;
   localparam int WEIGHT_LSB = PARENT_LSB + NODE_W;
   localparam int QU_LSB     = WEIGHT_LSB + WEIGHT_W;
   localparam int QV_LSB     = QU_LSB + NODE_W;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // ancestor entry: top bit marks "no ancestor"
   localparam logic [ANC_W-1:0]    ANC_NONE   = {1'b1, {NODE_W{1'b0}}};
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};

   function automatic logic [WEIGHT_W-1:0] smin(input logic [WEIGHT_W-1:0] a,
                                                input logic [WEIGHT_W-1:0] b);
      smin = ($signed(a) < $signed(b)) ? a : b;
   endfunction

endpackage

// File: rtl/tree_path_min_edge_query.sv
// Channel   Dir  Ports                          Contents
// request   in   req_tvalid/tready/tdata/tuser  tuser: req_type; tdata: load or query fields
// response  out  rsp_tvalid/tready/tdata/tuser  tdata: path_min_edge; tuser: no_edge
//
// A load writes the level 0 entry and depth, then per further level reads the ancestor's entry
// and writes its own (no read where no ancestor is left). A query lifts the deeper node, then
// both while their ancestors differ, via the single smin unit and the tables' one write / two
// read ports. Equal endpoints go straight to S_DONE. req_tready is high only while the
// sequencer idles. A held response stalls the sequencer in its final state only; reset is
// synchronous and leaves the tables as they are, node 0 reads as the root without being stored.
module tree_path_min_edge_query (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [9:0] child_node, [19:10] parent_node, [51:20] edge_weight,
   // [61:52] query_u, [71:62] query_v
   input  logic [tpme_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] req_type
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] path_min_edge
   output logic [tpme_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] no_edge
   output logic [0:0]                      rsp_tuser
);

   typedef enum logic [3:0] {
      S_IDLE, S_LD_DEP, S_LD_RD, S_LD_WR, S_Q_DEP, S_Q1_RD, S_Q1_EV, S_Q_MID,
      S_Q2_RD, S_Q2_EV, S_Q2_MV, S_QF_RD, S_QF_EV, S_QF_MV, S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [tpme_pkg::LVL_W-1:0]    level_ff, level_in;
   logic [tpme_pkg::NODE_W-1:0]   u_ff, u_in, v_ff, v_in, c_ff, c_in;
   logic [tpme_pkg::DEPTH_W-1:0]  dv_ff, dv_in;
   logic [tpme_pkg::WEIGHT_W-1:0] m_ff, m_in, mv_ff, mv_in, mc_ff, mc_in;
   logic [tpme_pkg::ANC_W-1:0]    e_ff, e_in;
   logic                          same_ff, same_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tpme_pkg::WEIGHT_W-1:0] rsp_data_ff, rsp_data_in;
   logic                          rsp_user_ff, rsp_user_in;

   // request fields
   logic                          in_type;
   logic [tpme_pkg::NODE_W-1:0]   in_child, in_parent, in_u, in_v;
   logic [tpme_pkg::WEIGHT_W-1:0] in_weight;

   assign in_type   = req_tuser[0];
   assign in_child  = req_tdata[tpme_pkg::CHILD_LSB +: tpme_pkg::NODE_W];
   assign in_parent = req_tdata[tpme_pkg::PARENT_LSB +: tpme_pkg::NODE_W];
   assign in_weight = req_tdata[tpme_pkg::WEIGHT_LSB +: tpme_pkg::WEIGHT_W];
   assign in_u      = req_tdata[tpme_pkg::QU_LSB +: tpme_pkg::NODE_W];
   assign in_v      = req_tdata[tpme_pkg::QV_LSB +: tpme_pkg::NODE_W];

   // table memories
   logic [tpme_pkg::ANC_W-1:0]    anc_mem [0:tpme_pkg::MEM_DEPTH-1];
   logic [tpme_pkg::WEIGHT_W-1:0] min_mem [0:tpme_pkg::MEM_DEPTH-1];
   logic [tpme_pkg::DEPTH_W-1:0]  dep_mem [0:tpme_pkg::MAX_NODES-1];

   logic [tpme_pkg::LVL_W-1:0]    rd_lvl, wr_lvl;
   logic [tpme_pkg::NODE_W-1:0]   rd_node_a, rd_node_b, wr_node;
   logic                          tab_we, dep_we;
   logic [tpme_pkg::ANC_W-1:0]    anc_wd;
   logic [tpme_pkg::WEIGHT_W-1:0] min_wd;
   logic [tpme_pkg::DEPTH_W-1:0]  dep_wd;

   logic [tpme_pkg::ANC_W-1:0]    anc_a_ff, anc_b_ff;
   logic [tpme_pkg::WEIGHT_W-1:0] min_a_ff, min_b_ff;
   logic [tpme_pkg::DEPTH_W-1:0]  dep_a_ff, dep_b_ff;
   logic                          root_a_ff, root_b_ff;

   logic [tpme_pkg::ADDR_W-1:0]   rd_addr_a, rd_addr_b, wr_addr;

   assign rd_addr_a = {rd_lvl, rd_node_a};
   assign rd_addr_b = {rd_lvl, rd_node_b};
   assign wr_addr   = {wr_lvl, wr_node};

   always_ff @(posedge clock) begin
      if (tab_we) begin
         anc_mem[wr_addr] <= anc_wd;
         min_mem[wr_addr] <= min_wd;
      end
      anc_a_ff <= anc_mem[rd_addr_a];
      anc_b_ff <= anc_mem[rd_addr_b];
      min_a_ff <= min_mem[rd_addr_a];
      min_b_ff <= min_mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (dep_we) begin
         dep_mem[c_ff] <= dep_wd;
      end
      dep_a_ff  <= dep_mem[rd_node_a];
      dep_b_ff  <= dep_mem[rd_node_b];
      root_a_ff <= (rd_node_a == '0);
      root_b_ff <= (rd_node_b == '0);
   end

   // the root is never stored: substitute its fixed entries
   logic [tpme_pkg::ANC_W-1:0]    anc_a, anc_b;
   logic [tpme_pkg::WEIGHT_W-1:0] min_a, min_b;
   logic [tpme_pkg::DEPTH_W-1:0]  dep_a, dep_b;

   assign anc_a = root_a_ff ? tpme_pkg::ANC_NONE   : anc_a_ff;
   assign anc_b = root_b_ff ? tpme_pkg::ANC_NONE   : anc_b_ff;
   assign min_a = root_a_ff ? tpme_pkg::WEIGHT_MAX : min_a_ff;
   assign min_b = root_b_ff ? tpme_pkg::WEIGHT_MAX : min_b_ff;
   assign dep_a = root_a_ff ? '0 : dep_a_ff;
   assign dep_b = root_b_ff ? '0 : dep_b_ff;

   // shared signed-minimum unit
   logic [tpme_pkg::WEIGHT_W-1:0] cmp_a, cmp_b, cmp_min;
   assign cmp_min = tpme_pkg::smin(cmp_a, cmp_b);

   logic [tpme_pkg::DIST_W-1:0] lift_reach;
   logic                        lift_ok;
   logic                        last_level;
   logic                        anc_a_none;

   assign lift_reach = tpme_pkg::DIST_W'(dv_ff) + (tpme_pkg::DIST_W'(1) << level_ff);
   assign anc_a_none = anc_a[tpme_pkg::NODE_W];
   assign lift_ok    = (tpme_pkg::DIST_W'(dep_a) >= lift_reach) && !anc_a_none;
   assign last_level = (level_ff == tpme_pkg::LVL_W'(tpme_pkg::LEVELS - 1));

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      c_in         = c_ff;
      dv_in        = dv_ff;
      m_in         = m_ff;
      mv_in        = mv_ff;
      mc_in        = mc_ff;
      e_in         = e_ff;
      same_in      = same_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      req_tready   = 1'b0;
      rd_lvl       = level_ff;
      rd_node_a    = u_ff;
      rd_node_b    = v_ff;
      tab_we       = 1'b0;
      dep_we       = 1'b0;
      wr_lvl       = level_ff;
      wr_node      = c_ff;
      anc_wd       = anc_a;
      min_wd       = cmp_min;
      dep_wd       = dep_a + tpme_pkg::DEPTH_W'(1);
      cmp_a        = m_ff;
      cmp_b        = min_a;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (in_type == tpme_pkg::REQ_LOAD) begin
                  // level 0 entry goes in right away; fetch parent depth
                  rd_node_a = in_parent;
                  if (in_child != '0) begin
                     tab_we   = 1'b1;
                     wr_lvl   = '0;
                     wr_node  = in_child;
                     anc_wd   = {1'b0, in_parent};
                     min_wd   = in_weight;
                     c_in     = in_child;
                     e_in     = {1'b0, in_parent};
                     mc_in    = in_weight;
                     level_in = tpme_pkg::LVL_W'(1);
                     state_in = S_LD_DEP;
                  end
               end else begin
                  rd_node_a = in_u;
                  rd_node_b = in_v;
                  u_in      = in_u;
                  v_in      = in_v;
                  m_in      = tpme_pkg::WEIGHT_MAX;
                  same_in   = (in_u == in_v);
                  level_in  = tpme_pkg::LVL_W'(tpme_pkg::LEVELS - 1);
                  state_in  = (in_u == in_v) ? S_DONE : S_Q_DEP;
               end
            end
         end

         S_LD_DEP: begin
            dep_we   = 1'b1;
            state_in = (tpme_pkg::LEVELS > 1) ? S_LD_RD : S_IDLE;
         end

         S_LD_RD: begin
            if (e_ff[tpme_pkg::NODE_W]) begin
               // no ancestor below: the rest of the row is empty
               tab_we = 1'b1;
               anc_wd = tpme_pkg::ANC_NONE;
               min_wd = tpme_pkg::WEIGHT_MAX;
               if (last_level) begin
                  state_in = S_IDLE;
               end else begin
                  level_in = level_ff + tpme_pkg::LVL_W'(1);
               end
            end else begin
               rd_lvl    = level_ff - tpme_pkg::LVL_W'(1);
               rd_node_a = e_ff[tpme_pkg::NODE_W-1:0];
               state_in  = S_LD_WR;
            end
         end

         S_LD_WR: begin
            cmp_a  = mc_ff;
            tab_we = 1'b1;
            e_in   = anc_a;
            mc_in  = cmp_min;
            if (last_level) begin
               state_in = S_IDLE;
            end else begin
               level_in = level_ff + tpme_pkg::LVL_W'(1);
               state_in = S_LD_RD;
            end
         end

         S_Q_DEP: begin
            // deeper node goes to u
            if (dep_a < dep_b) begin
               u_in  = v_ff;
               v_in  = u_ff;
               dv_in = dep_a;
            end else begin
               dv_in = dep_b;
            end
            level_in = tpme_pkg::LVL_W'(tpme_pkg::LEVELS - 1);
            state_in = S_Q1_RD;
         end

         S_Q1_RD: begin
            state_in = S_Q1_EV;
         end

         S_Q1_EV: begin
            if (lift_ok) begin
               m_in = cmp_min;
               u_in = anc_a[tpme_pkg::NODE_W-1:0];
            end
            if (level_ff == '0) begin
               state_in = S_Q_MID;
            end else begin
               level_in = level_ff - tpme_pkg::LVL_W'(1);
               state_in = S_Q1_RD;
            end
         end

         S_Q_MID: begin
            level_in = tpme_pkg::LVL_W'(tpme_pkg::LEVELS - 1);
            state_in = (u_ff == v_ff) ? S_DONE : S_Q2_RD;
         end

         S_Q2_RD: begin
            state_in = S_Q2_EV;
         end

         S_Q2_EV: begin
            if (!anc_a_none && (anc_a != anc_b)) begin
               m_in     = cmp_min;
               mv_in    = min_b;
               u_in     = anc_a[tpme_pkg::NODE_W-1:0];
               v_in     = anc_b[tpme_pkg::NODE_W-1:0];
               state_in = S_Q2_MV;
            end else if (level_ff == '0) begin
               state_in = S_QF_RD;
            end else begin
               level_in = level_ff - tpme_pkg::LVL_W'(1);
               state_in = S_Q2_RD;
            end
         end

         S_Q2_MV: begin
            cmp_b = mv_ff;
            m_in  = cmp_min;
            if (level_ff == '0) begin
               state_in = S_QF_RD;
            end else begin
               level_in = level_ff - tpme_pkg::LVL_W'(1);
               state_in = S_Q2_RD;
            end
         end

         S_QF_RD: begin
            rd_lvl   = '0;
            state_in = S_QF_EV;
         end

         S_QF_EV: begin
            m_in     = cmp_min;
            mv_in    = min_b;
            state_in = S_QF_MV;
         end

         S_QF_MV: begin
            cmp_b    = mv_ff;
            m_in     = cmp_min;
            state_in = S_DONE;
         end

         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = m_ff;
               rsp_user_in  = same_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      level_ff    <= level_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      c_ff        <= c_in;
      dv_ff       <= dv_in;
      m_ff        <= m_in;
      mv_ff       <= mv_in;
      mc_ff       <= mc_in;
      e_ff        <= e_in;
      same_ff     <= same_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

   a_same_is_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == tpme_pkg::WEIGHT_MAX)
      else $error("no_edge response without maximum weight");

   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == tpme_pkg::REQ_LOAD)
      && (in_child != '0) |=> !req_tready)
      else $error("sequencer idle right after a load request");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> level_ff <= tpme_pkg::LVL_W'(tpme_pkg::LEVELS - 1))
      else $error("level counter out of range");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the final state");

endmodule

// File: verif/tb_tree_path_min_edge_query.sv
`timescale 1ns / 1ps

module tb_tree_path_min_edge_query;

   localparam int RANDOM_ITEMS = 600;
   // slowest run: ~1700 items plus response stalls and sender gaps
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 5 * tpme_pkg::LEVELS + 16;

   typedef struct {
      logic signed [tpme_pkg::WEIGHT_W-1:0] min_w;
      logic                                 no_edge;
   } path_answer_type;

   // Tree tables mirrored from the load stream, and the answers still owed by the block.
   class path_min_scoreboard;
      logic [tpme_pkg::ANC_W-1:0]
         anc_entry [tpme_pkg::LEVELS][tpme_pkg::MAX_NODES];
      logic signed [tpme_pkg::WEIGHT_W-1:0]
         hop_min [tpme_pkg::LEVELS][tpme_pkg::MAX_NODES];
      logic [tpme_pkg::DEPTH_W-1:0] node_depth [tpme_pkg::MAX_NODES];
      path_answer_type              owed [$];
      int errors, n_loads, n_queries, n_same, n_checked;

      function new();
         for (int k = 0; k < tpme_pkg::LEVELS; k++) begin
            for (int n = 0; n < tpme_pkg::MAX_NODES; n++) begin
               anc_entry[k][n] = '0;
               hop_min[k][n]   = '0;
            end
            anc_entry[k][0] = tpme_pkg::ANC_NONE;
            hop_min[k][0]   = tpme_pkg::WEIGHT_MAX;
         end
         for (int n = 0; n < tpme_pkg::MAX_NODES; n++) node_depth[n] = '0;
         errors = 0;
         n_loads = 0;
         n_queries = 0;
         n_same = 0;
         n_checked = 0;
      endfunction

      function logic signed [tpme_pkg::WEIGHT_W-1:0] lesser(
         logic signed [tpme_pkg::WEIGHT_W-1:0] a,
         logic signed [tpme_pkg::WEIGHT_W-1:0] b);
         return (a < b) ? a : b;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      task report(string msg);
         $display("[%0t] MISMATCH: %s", $time, msg);
         errors++;
      endtask

      function void build_node(logic [tpme_pkg::NODE_W-1:0] c,
                               logic [tpme_pkg::NODE_W-1:0] p,
                               logic signed [tpme_pkg::WEIGHT_W-1:0] w);
         logic [tpme_pkg::ANC_W-1:0]  e;
         logic [tpme_pkg::NODE_W-1:0] a;
         if (c == 0) return;
         anc_entry[0][c] = {1'b0, p};
         hop_min[0][c]   = w;
         node_depth[c]   = node_depth[p] + 1'b1;
         for (int k = 1; k < tpme_pkg::LEVELS; k++) begin
            e = anc_entry[k-1][c];
            if (e[tpme_pkg::NODE_W]) begin
               anc_entry[k][c] = tpme_pkg::ANC_NONE;
               hop_min[k][c]   = tpme_pkg::WEIGHT_MAX;
            end else begin
               a = e[tpme_pkg::NODE_W-1:0];
               anc_entry[k][c] = anc_entry[k-1][a];
               hop_min[k][c]   = lesser(hop_min[k-1][c], hop_min[k-1][a]);
            end
         end
      endfunction

      function path_answer_type walk_path(logic [tpme_pkg::NODE_W-1:0] u_in,
                                          logic [tpme_pkg::NODE_W-1:0] v_in);
         path_answer_type             ans;
         logic [tpme_pkg::NODE_W-1:0] u, v, t;
         logic [tpme_pkg::ANC_W-1:0]  eu, ev;
         u = u_in;
         v = v_in;
         ans.min_w   = tpme_pkg::WEIGHT_MAX;
         ans.no_edge = (u == v);
         if (ans.no_edge) return ans;
         if (node_depth[u] < node_depth[v]) begin
            t = u;
            u = v;
            v = t;
         end
         // bring the deeper node up to the other one's depth
         for (int k = tpme_pkg::LEVELS - 1; k >= 0; k--) begin
            eu = anc_entry[k][u];
            if (int'(node_depth[u]) >= int'(node_depth[v]) + (1 << k)
                && !eu[tpme_pkg::NODE_W]) begin
               ans.min_w = lesser(ans.min_w, hop_min[k][u]);
               u = eu[tpme_pkg::NODE_W-1:0];
            end
         end
         if (u == v) return ans;
         // climb both while the ancestors still differ
         for (int k = tpme_pkg::LEVELS - 1; k >= 0; k--) begin
            eu = anc_entry[k][u];
            ev = anc_entry[k][v];
            if (!eu[tpme_pkg::NODE_W] && eu != ev) begin
               ans.min_w = lesser(ans.min_w, lesser(hop_min[k][u], hop_min[k][v]));
               u = eu[tpme_pkg::NODE_W-1:0];
               v = ev[tpme_pkg::NODE_W-1:0];
            end
         end
         ans.min_w = lesser(ans.min_w, lesser(hop_min[0][u], hop_min[0][v]));
         return ans;
      endfunction

      function void note_request(logic kind, logic [tpme_pkg::REQ_DATA_W-1:0] data);
         path_answer_type ans;
         if (kind == tpme_pkg::REQ_LOAD) begin
            build_node(data[tpme_pkg::CHILD_LSB +: tpme_pkg::NODE_W],
                       data[tpme_pkg::PARENT_LSB +: tpme_pkg::NODE_W],
                       data[tpme_pkg::WEIGHT_LSB +: tpme_pkg::WEIGHT_W]);
            n_loads++;
         end else begin
            ans = walk_path(data[tpme_pkg::QU_LSB +: tpme_pkg::NODE_W],
                            data[tpme_pkg::QV_LSB +: tpme_pkg::NODE_W]);
            owed.push_back(ans);
            n_queries++;
            if (ans.no_edge) n_same++;
         end
      endfunction

      task check_response(logic [tpme_pkg::RSP_DATA_W-1:0] data, logic [0:0] flag);
         path_answer_type ans;
         if (owed.size() == 0) begin
            report($sformatf("response %h/%b with no query outstanding", data, flag));
            return;
         end
         ans = owed.pop_front();
         n_checked++;
         if (data !== ans.min_w)
            report($sformatf("path_min_edge %h, want %h (response %0d)",
                             data, ans.min_w, n_checked));
         if (flag !== ans.no_edge)
            report($sformatf("no_edge %b, want %b (response %0d)",
                             flag, ans.no_edge, n_checked));
      endtask
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [tpme_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]                      req_tuser = tpme_pkg::REQ_LOAD;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [tpme_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]                      rsp_tuser;

   path_min_scoreboard sb = new();

   logic [tpme_pkg::NODE_W-1:0] tree_nodes [$];
   bit          in_tree [tpme_pkg::MAX_NODES];
   int          burst_left = 0;
   int          cycle_count = 0;
   int          pat_mode = 0;
   int          pat_left = 0;
   int          n_reloads = 0;
   int          n_root_loads = 0;

   tree_path_min_edge_query u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d answers outstanding",
                  cycle_count, sb.pending());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Check responses, then pick the next ready level from the current stall pattern.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
      if (pat_left == 0) begin
         pat_mode <= $urandom_range(0, 3);
         pat_left <= $urandom_range(20, 300);
      end else begin
         pat_left <= pat_left - 1;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         case (pat_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 1);
            2: rsp_tready <= ($urandom_range(0, 7) == 0);
            default: rsp_tready <= cycle_count[3];
         endcase
      end
   end

   task automatic push_request(input logic kind,
                               input logic [tpme_pkg::REQ_DATA_W-1:0] data);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, data);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 10);
      end
   endtask

   task automatic send_load(input logic [tpme_pkg::NODE_W-1:0] c,
                            input logic [tpme_pkg::NODE_W-1:0] p,
                            input logic [tpme_pkg::WEIGHT_W-1:0] w);
      logic [tpme_pkg::NODE_W-1:0] qu, qv;
      qu = tpme_pkg::NODE_W'($urandom());
      qv = tpme_pkg::NODE_W'($urandom());
      if (c == 0) n_root_loads++;
      else if (in_tree[c]) n_reloads++;
      push_request(tpme_pkg::REQ_LOAD, {qv, qu, w, p, c});
      if (c != 0 && !in_tree[c]) begin
         in_tree[c] = 1'b1;
         tree_nodes.push_back(c);
      end
   endtask

   task automatic send_query(input logic [tpme_pkg::NODE_W-1:0] u,
                             input logic [tpme_pkg::NODE_W-1:0] v);
      logic [tpme_pkg::WEIGHT_W-1:0] w;
      logic [tpme_pkg::NODE_W-1:0]   c, p;
      w = $urandom();
      c = tpme_pkg::NODE_W'($urandom());
      p = tpme_pkg::NODE_W'($urandom());
      push_request(tpme_pkg::REQ_QUERY, {v, u, w, p, c});
   endtask

   task automatic wait_all_answered();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [tpme_pkg::WEIGHT_W-1:0] pick_weight();
      logic [tpme_pkg::WEIGHT_W-1:0] w;
      case ($urandom_range(0, 9))
         0: w = {1'b1, {(tpme_pkg::WEIGHT_W-1){1'b0}}};
         1: w = tpme_pkg::WEIGHT_MAX;
         2: w = '0;
         3: w = '1;
         4, 5: begin
            // narrow range so that equal weights show up on paths
            w = $urandom_range(0, 31);
            w = w - 16;
         end
         default: w = $urandom();
      endcase
      return w;
   endfunction

   function automatic logic [tpme_pkg::NODE_W-1:0] pick_node();
      return tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
   endfunction

   task automatic send_random_query();
      logic [tpme_pkg::NODE_W-1:0] u, v;
      int roll;
      u = pick_node();
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         v = u;
      end else if (roll < 35) begin
         // endpoint on the way up from the other one
         v = u;
         repeat ($urandom_range(1, 40))
            if (!sb.anc_entry[0][v][tpme_pkg::NODE_W])
               v = sb.anc_entry[0][v][tpme_pkg::NODE_W-1:0];
      end else if (roll < 45) begin
         v = '0;
      end else begin
         v = pick_node();
      end
      if ($urandom_range(0, 1)) send_query(u, v);
      else send_query(v, u);
   endtask

   initial begin
      logic [tpme_pkg::NODE_W-1:0] next_node, last_built, c, p, deepest;
      int n_items, roll, deepest_depth;

      tree_nodes.push_back(0);
      in_tree[0] = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, root load, parent above child, reload under a new parent
      send_query(0, 0);
      send_load(0, 0, 32'h1234_5678);
      send_load(1, 0, 32'h8000_0000);
      send_load(2, 1, 32'h7FFF_FFFF);
      send_load(3, 0, 32'h0000_0000);
      send_load(4, 2, 32'hFFFF_FFFF);
      send_query(1, 0);
      send_query(0, 2);
      send_query(2, 3);
      send_query(4, 3);
      send_query(4, 4);
      send_query(4, 2);
      send_load(1023, 4, 32'h5A5A_A5A5);
      send_query(1023, 0);
      send_query(3, 1023);
      send_load(5, 1023, 32'h0000_0007);
      send_query(5, 3);
      send_load(2, 3, 32'h0000_0064);
      send_query(4, 3);
      send_query(2, 1);
      send_load(0, 5, 32'hDEAD_BEEF);
      send_query(1023, 1023);
      wait_all_answered();

      // random: grow the tree mostly as long chains, with queries and reloads mixed in
      next_node  = 6;
      last_built = 5;
      n_items    = 0;
      while (n_items < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            send_load(0, pick_node(), pick_weight());
         end else begin
            n_items++;
            if (roll < 9) begin
               do c = pick_node(); while (c == 0);
               send_load(c, pick_node(), pick_weight());
            end else if (roll < 70 && next_node < tpme_pkg::MAX_NODES - 1) begin
               case ($urandom_range(0, 9))
                  8: p = pick_node();
                  9: p = tree_nodes[$urandom_range(0, 6)];
                  default: p = last_built;
               endcase
               send_load(next_node, p, pick_weight());
               last_built = next_node;
               next_node++;
            end else begin
               send_random_query();
            end
         end
      end
      wait_all_answered();

      // wrap the depth of the deepest node by making it its own parent over and over
      deepest = 0;
      foreach (tree_nodes[i])
         if (sb.node_depth[tree_nodes[i]] > sb.node_depth[deepest]) deepest = tree_nodes[i];
      deepest_depth = sb.node_depth[deepest];
      do send_load(deepest, deepest, pick_weight()); while (sb.node_depth[deepest] != 0);
      repeat (20) begin
         p = pick_node();
         if ($urandom_range(0, 1)) send_query(deepest, p);
         else send_query(p, deepest);
      end
      send_load(deepest, deepest, pick_weight());
      repeat (20) send_random_query();
      send_query(deepest, 0);

      wait_all_answered();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d loads (%0d reloads, %0d root loads), %0d nodes in the tree",
               sb.n_loads, n_reloads, n_root_loads, tree_nodes.size());
      $display("covered %0d queries (%0d equal endpoints), depth wrap from %0d, %0d cycles",
               sb.n_queries, sb.n_same, deepest_depth, cycle_count);
      if (sb.pending() != 0) sb.report($sformatf("%0d answers never arrived", sb.pending()));
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/tpme_pkg.sv
rtl/tree_path_min_edge_query.sv
verif/tb_tree_path_min_edge_query.sv
